// ----- rtl/core/ucfc_pkg.sv -----
// ----------------------------------------------------------------------------
// ucfc_pkg
// Shared types and constants of the command frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ucfc_pkg;

    localparam logic [7:0] FRAME_OPEN  = 8'h53;
    localparam logic [7:0] FRAME_CLOSE = 8'hAA;
    localparam logic [7:0] CHECK_REPLY = 8'h0F;

    localparam logic [7:0] CMD_CHECK    = 8'h00;
    localparam logic [7:0] CMD_SWITCHES = 8'h01;
    localparam logic [7:0] CMD_POT1     = 8'h02;
    localparam logic [7:0] CMD_POT2     = 8'h03;
    localparam logic [7:0] CMD_TEMP     = 8'h04;
    localparam logic [7:0] CMD_LIGHT    = 8'h05;
    localparam logic [7:0] CMD_PORTC    = 8'h0A;
    localparam logic [7:0] CMD_HEATER   = 8'h0B;
    localparam logic [7:0] CMD_LAMP     = 8'h0C;
    localparam logic [7:0] CMD_MOTOR    = 8'h0D;

    localparam logic [1:0] CH_LIGHT = 2'd0;
    localparam logic [1:0] CH_POT2  = 2'd1;
    localparam logic [1:0] CH_POT1  = 2'd2;
    localparam logic [1:0] CH_TEMP  = 2'd3;

    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_LONG  = 3'd5;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_CMD    = 3'd1,
        PH_FIRST  = 3'd2,
        PH_SECOND = 3'd3,
        PH_END    = 3'd4
    } rx_phase_t;

    typedef struct packed {
        logic [7:0]  port_c;
        logic        heater_en;
        logic        light_en;
        logic        fan_en;
        logic [15:0] heater_duty;
        logic [15:0] light_duty;
        logic [15:0] motor_duty;
        logic [1:0]  channel;
    } status_t;

    typedef struct packed {
        logic [4:0][7:0] bytes;
        logic [2:0]      len;
        status_t         status;
    } reply_t;

endpackage

`default_nettype wire

// ----- rtl/core/uart_command_frame_controller.sv -----
// ----------------------------------------------------------------------------
// uart_command_frame_controller
// Parses received command frames, carries out each closed frame and
// streams the reply frame out byte by byte with the output state attached.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals                       | Beat carries
// s       | in        | s_tvalid s_tready s_tdata/user | one received byte or ADC word
// m       | out       | m_tvalid m_tready m_tdata/last | one reply byte plus status
//
// An input beat is taken into an input register and executed from there;
// a beat that causes no reply leaves the input register at once, so
// such beats flow at one per cycle. A reply of 3 or 5 beats is sent one
// beat per cycle from the reply buffer while m_tready is high; a replying
// beat waits in the input register until the buffer is empty or its
// final beat is taken. Reset clears the receive phase and all output state.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_command_frame_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte[7:0], adc_word[23:8], switch_pins[31:24]
    input  wire logic        s_tuser,   // kind
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [71:0] m_tdata,   // tx_byte[7:0], port_c_level[15:8],
                                        // heater_enable[16], light_enable[17],
                                        // fan_enable[18], heater_duty[34:19],
                                        // light_duty[50:35], motor_duty[66:51],
                                        // adc_channel[68:67], zeros[71:69]
    output      logic        m_tlast    // last_byte
);

    logic              in_valid_reg;
    logic              kind_reg;
    logic [7:0]        rx_byte_reg;
    logic [15:0]       adc_word_reg;
    logic [7:0]        pins_reg;
    logic              advance;
    logic              reply_req;
    logic              tx_free;
    logic [7:0]        tx_byte;
    ucfc_pkg::reply_t  reply;
    ucfc_pkg::status_t status;

    assign advance  = in_valid_reg && (!reply_req || tx_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            kind_reg     <= s_tuser;
            rx_byte_reg  <= s_tdata[7:0];
            adc_word_reg <= s_tdata[23:8];
            pins_reg     <= s_tdata[31:24];
        end
    end

    ucfc_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (advance),
        .kind        (kind_reg),
        .rx_byte     (rx_byte_reg),
        .adc_word    (adc_word_reg),
        .switch_pins (pins_reg),
        .reply_req   (reply_req),
        .reply       (reply)
    );

    ucfc_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && reply_req),
        .reply   (reply),
        .free    (tx_free),
        .valid   (m_tvalid),
        .ready   (m_tready),
        .tx_byte (tx_byte),
        .last    (m_tlast),
        .status  (status)
    );

    assign m_tdata = {3'b000, status.channel, status.motor_duty, status.light_duty,
                      status.heater_duty, status.fan_en, status.light_en,
                      status.heater_en, status.port_c, tx_byte};

endmodule

`default_nettype wire

// ----- rtl/core/ucfc_exec.sv -----
// ----------------------------------------------------------------------------
// ucfc_exec
// Frame parser and command executor: holds the receive phase, the frame
// bytes and all output state, and builds the reply frame of a closed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfc_exec (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic             kind,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [15:0]      adc_word,
    input  wire logic [7:0]       switch_pins,
    output      logic             reply_req,
    output      ucfc_pkg::reply_t reply
);

    ucfc_pkg::rx_phase_t phase_reg, phase_next;
    logic [7:0]  cmd_reg, first_reg, second_reg;
    logic [7:0]  portc_reg, portc_next;
    logic [2:0]  en_reg, en_next;
    logic [15:0] heater_duty_reg, heater_duty_next;
    logic [15:0] light_duty_reg, light_duty_next;
    logic [15:0] motor_duty_reg, motor_duty_next;
    logic [15:0] conv_reg;
    logic        seen_reg;
    logic [1:0]  chan_reg, chan_next;

    logic        frame_done;
    logic        known;
    logic        short_reply;
    logic [7:0]  reply_code;
    logic [15:0] word;
    logic [15:0] adc_val;
    logic        data_zero;
    logic [15:0] data_word;

    // The end byte only counts in the first-data slot; the end slot takes any byte.
    assign frame_done = !kind && ((phase_reg == ucfc_pkg::PH_FIRST
                        && rx_byte == ucfc_pkg::FRAME_CLOSE)
                        || phase_reg == ucfc_pkg::PH_END);
    assign adc_val    = seen_reg ? conv_reg : 16'h0000;
    assign data_zero  = (first_reg == 8'h00) && (second_reg == 8'h00);
    assign data_word  = {first_reg, second_reg};
    assign reply_req  = frame_done && known;

    // Next receive phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (!kind)
        begin
            unique case (phase_reg)
                ucfc_pkg::PH_CMD:    phase_next = ucfc_pkg::PH_FIRST;
                ucfc_pkg::PH_FIRST:
                begin
                    if (rx_byte == ucfc_pkg::FRAME_CLOSE)
                        phase_next = ucfc_pkg::PH_WAIT;
                    else
                        phase_next = ucfc_pkg::PH_SECOND;
                end
                ucfc_pkg::PH_SECOND: phase_next = ucfc_pkg::PH_END;
                ucfc_pkg::PH_END:    phase_next = ucfc_pkg::PH_WAIT;
                default:
                begin
                    if (rx_byte == ucfc_pkg::FRAME_OPEN)
                        phase_next = ucfc_pkg::PH_CMD;
                    else
                        phase_next = ucfc_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Command execution and reply construction.
    always_comb
    begin
        portc_next       = portc_reg;
        en_next          = en_reg;
        heater_duty_next = heater_duty_reg;
        light_duty_next  = light_duty_reg;
        motor_duty_next  = motor_duty_reg;
        chan_next        = chan_reg;
        known            = 1'b1;
        short_reply      = 1'b0;
        reply_code       = cmd_reg;
        word             = 16'h0000;
        unique case (cmd_reg)
            ucfc_pkg::CMD_CHECK:
            begin
                short_reply = 1'b1;
                reply_code  = ucfc_pkg::CHECK_REPLY;
            end
            ucfc_pkg::CMD_SWITCHES: word = {8'h00, switch_pins};
            ucfc_pkg::CMD_POT1:
            begin
                chan_next = ucfc_pkg::CH_POT1;
                word      = adc_val;
            end
            ucfc_pkg::CMD_POT2:
            begin
                chan_next = ucfc_pkg::CH_POT2;
                word      = adc_val;
            end
            ucfc_pkg::CMD_TEMP:
            begin
                chan_next = ucfc_pkg::CH_TEMP;
                word      = adc_val;
            end
            ucfc_pkg::CMD_LIGHT:
            begin
                chan_next = ucfc_pkg::CH_LIGHT;
                word      = adc_val;
            end
            ucfc_pkg::CMD_PORTC:
            begin
                portc_next  = first_reg;
                short_reply = 1'b1;
            end
            ucfc_pkg::CMD_HEATER:
            begin
                en_next[0] = !data_zero;
                if (!data_zero)
                    heater_duty_next = data_word;
                word = heater_duty_next;
            end
            ucfc_pkg::CMD_LAMP:
            begin
                en_next[1] = !data_zero;
                if (!data_zero)
                    light_duty_next = data_word;
                word = light_duty_next;
            end
            ucfc_pkg::CMD_MOTOR:
            begin
                // Only the motor clears its compare value when switched off.
                en_next[2]      = !data_zero;
                motor_duty_next = data_word;
                word            = motor_duty_next;
            end
            default: known = 1'b0;
        endcase

        reply.bytes[0] = ucfc_pkg::FRAME_OPEN;
        reply.bytes[1] = reply_code;
        if (short_reply)
        begin
            reply.bytes[2] = ucfc_pkg::FRAME_CLOSE;
            reply.bytes[3] = 8'h00;
            reply.bytes[4] = 8'h00;
            reply.len      = ucfc_pkg::LEN_SHORT;
        end
        else
        begin
            reply.bytes[2] = word[15:8];
            reply.bytes[3] = word[7:0];
            reply.bytes[4] = ucfc_pkg::FRAME_CLOSE;
            reply.len      = ucfc_pkg::LEN_LONG;
        end
        reply.status.port_c      = portc_next;
        reply.status.heater_en   = en_next[0];
        reply.status.light_en    = en_next[1];
        reply.status.fan_en      = en_next[2];
        reply.status.heater_duty = heater_duty_next;
        reply.status.light_duty  = light_duty_next;
        reply.status.motor_duty  = motor_duty_next;
        reply.status.channel     = chan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ucfc_pkg::PH_WAIT;
            cmd_reg         <= 8'h00;
            first_reg       <= 8'h00;
            second_reg      <= 8'h00;
            portc_reg       <= 8'h00;
            en_reg          <= 3'b000;
            heater_duty_reg <= 16'h0000;
            light_duty_reg  <= 16'h0000;
            motor_duty_reg  <= 16'h0000;
            conv_reg        <= 16'h0000;
            seen_reg        <= 1'b0;
            chan_reg        <= ucfc_pkg::CH_LIGHT;
        end
        else if (go)
        begin
            if (kind)
            begin
                conv_reg <= adc_word;
                seen_reg <= 1'b1;
            end
            else
            begin
                phase_reg <= phase_next;
                if (phase_reg == ucfc_pkg::PH_CMD)
                    cmd_reg <= rx_byte;
                if (phase_reg == ucfc_pkg::PH_FIRST && rx_byte != ucfc_pkg::FRAME_CLOSE)
                    first_reg <= rx_byte;
                if (phase_reg == ucfc_pkg::PH_SECOND)
                    second_reg <= rx_byte;
                if (reply_req)
                begin
                    portc_reg       <= portc_next;
                    en_reg          <= en_next;
                    heater_duty_reg <= heater_duty_next;
                    light_duty_reg  <= light_duty_next;
                    motor_duty_reg  <= motor_duty_next;
                    chan_reg        <= chan_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ucfc_tx.sv -----
// ----------------------------------------------------------------------------
// ucfc_tx
// Reply buffer: holds one reply frame and sends it one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfc_tx (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ucfc_pkg::reply_t reply,
    output      logic             free,
    output      logic             valid,
    input  wire logic             ready,
    output      logic [7:0]       tx_byte,
    output      logic             last,
    output      ucfc_pkg::status_t status
);

    logic [4:0][7:0]   bytes_reg;
    ucfc_pkg::status_t status_reg;
    logic [2:0]        cnt_reg;
    logic [2:0]        idx_reg;

    assign valid   = (cnt_reg != 3'd0);
    assign last    = (cnt_reg == 3'd1);
    assign free    = !valid || (last && ready);
    assign tx_byte = bytes_reg[idx_reg];
    assign status  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 3'd0;
        end
        else if (load && free)
        begin
            cnt_reg <= reply.len;
            idx_reg <= 3'd0;
        end
        else if (valid && ready)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            bytes_reg  <= reply.bytes;
            status_reg <= reply.status;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_uart_command_frame_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_command_frame_controller
// Feeds command frames, ADC conversion words and line noise into the frame
// controller. The replies and status fields are predicted in the testbench
// and every reply beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_uart_command_frame_controller;

    localparam int ITEM_TARGET  = 430;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT_ITEM = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 280;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] KNOWN_CMDS [10] = '{
        ucfc_pkg::CMD_CHECK, ucfc_pkg::CMD_SWITCHES, ucfc_pkg::CMD_POT1,
        ucfc_pkg::CMD_POT2, ucfc_pkg::CMD_TEMP, ucfc_pkg::CMD_LIGHT,
        ucfc_pkg::CMD_PORTC, ucfc_pkg::CMD_HEATER, ucfc_pkg::CMD_LAMP,
        ucfc_pkg::CMD_MOTOR
    };

    typedef struct {
        logic [7:0]        tx_byte;
        logic              last_byte;
        ucfc_pkg::status_t status;
    } reply_beat_t;

    class reply_scoreboard;
        ucfc_pkg::rx_phase_t phase;
        logic [7:0]  cmd_code;
        logic [7:0]  data_hi;
        logic [7:0]  data_lo;
        logic [7:0]  port_c;
        logic [2:0]  enables;     // heater, light, fan from bit 0 up
        logic [15:0] duties [3];  // heater, light, motor
        logic [15:0] adc_word;
        logic        adc_seen;
        logic [1:0]  channel;
        reply_beat_t replies [$];
        int          errors;

        function new();
            phase    = ucfc_pkg::PH_WAIT;
            cmd_code = 8'h00;
            data_hi  = 8'h00;
            data_lo  = 8'h00;
            port_c   = 8'h00;
            enables  = 3'b000;
            duties   = '{16'h0000, 16'h0000, 16'h0000};
            adc_word = 16'h0000;
            adc_seen = 1'b0;
            channel  = ucfc_pkg::CH_LIGHT;
            errors   = 0;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void push_reply(input logic [7:0] b, input logic last);
            reply_beat_t beat;
            beat.tx_byte            = b;
            beat.last_byte          = last;
            beat.status.port_c      = port_c;
            beat.status.heater_en   = enables[0];
            beat.status.light_en    = enables[1];
            beat.status.fan_en      = enables[2];
            beat.status.heater_duty = duties[0];
            beat.status.light_duty  = duties[1];
            beat.status.motor_duty  = duties[2];
            beat.status.channel     = channel;
            replies.push_back(beat);
        endfunction

        function void reply_short(input logic [7:0] b);
            push_reply(ucfc_pkg::FRAME_OPEN, 1'b0);
            push_reply(b, 1'b0);
            push_reply(ucfc_pkg::FRAME_CLOSE, 1'b1);
        endfunction

        function void reply_word(input logic [7:0] cmd, input logic [15:0] word);
            push_reply(ucfc_pkg::FRAME_OPEN, 1'b0);
            push_reply(cmd, 1'b0);
            push_reply(word[15:8], 1'b0);
            push_reply(word[7:0], 1'b0);
            push_reply(ucfc_pkg::FRAME_CLOSE, 1'b1);
        endfunction

        function void set_pwm(input logic [7:0] cmd, input int idx);
            if (data_hi == 8'h00 && data_lo == 8'h00)
            begin
                enables[idx] = 1'b0;
                // Only the motor drops its compare value when switched off.
                if (cmd == ucfc_pkg::CMD_MOTOR)
                begin
                    duties[idx] = 16'h0000;
                end
            end
            else
            begin
                enables[idx] = 1'b1;
                duties[idx]  = {data_hi, data_lo};
            end
            reply_word(cmd, duties[idx]);
        endfunction

        function void execute(input logic [7:0] pins);
            logic [15:0] adc_now;
            adc_now = adc_seen ? adc_word : 16'h0000;
            case (cmd_code)
                ucfc_pkg::CMD_CHECK:    reply_short(ucfc_pkg::CHECK_REPLY);
                ucfc_pkg::CMD_SWITCHES: reply_word(ucfc_pkg::CMD_SWITCHES, {8'h00, pins});
                ucfc_pkg::CMD_POT1:
                begin
                    channel = ucfc_pkg::CH_POT1;
                    reply_word(ucfc_pkg::CMD_POT1, adc_now);
                end
                ucfc_pkg::CMD_POT2:
                begin
                    channel = ucfc_pkg::CH_POT2;
                    reply_word(ucfc_pkg::CMD_POT2, adc_now);
                end
                ucfc_pkg::CMD_TEMP:
                begin
                    channel = ucfc_pkg::CH_TEMP;
                    reply_word(ucfc_pkg::CMD_TEMP, adc_now);
                end
                ucfc_pkg::CMD_LIGHT:
                begin
                    channel = ucfc_pkg::CH_LIGHT;
                    reply_word(ucfc_pkg::CMD_LIGHT, adc_now);
                end
                ucfc_pkg::CMD_PORTC:
                begin
                    port_c = data_hi;
                    reply_short(ucfc_pkg::CMD_PORTC);
                end
                ucfc_pkg::CMD_HEATER:   set_pwm(ucfc_pkg::CMD_HEATER, 0);
                ucfc_pkg::CMD_LAMP:     set_pwm(ucfc_pkg::CMD_LAMP, 1);
                ucfc_pkg::CMD_MOTOR:    set_pwm(ucfc_pkg::CMD_MOTOR, 2);
                default:      ;  // An unknown command is consumed silently.
            endcase
        endfunction

        function void note_input(input logic kind, input logic [31:0] d);
            logic [7:0] rx;
            rx = d[7:0];
            if (kind)
            begin
                adc_word = d[23:8];
                adc_seen = 1'b1;
            end
            else
            begin
                case (phase)
                    ucfc_pkg::PH_CMD:
                    begin
                        cmd_code = rx;
                        phase    = ucfc_pkg::PH_FIRST;
                    end
                    ucfc_pkg::PH_FIRST:
                    begin
                        // A close byte here ends the frame and keeps the old data.
                        if (rx == ucfc_pkg::FRAME_CLOSE)
                        begin
                            phase = ucfc_pkg::PH_WAIT;
                            execute(d[31:24]);
                        end
                        else
                        begin
                            data_hi = rx;
                            phase   = ucfc_pkg::PH_SECOND;
                        end
                    end
                    ucfc_pkg::PH_SECOND:
                    begin
                        data_lo = rx;
                        phase   = ucfc_pkg::PH_END;
                    end
                    ucfc_pkg::PH_END:
                    begin
                        phase = ucfc_pkg::PH_WAIT;
                        execute(d[31:24]);
                    end
                    default:
                    begin
                        if (rx == ucfc_pkg::FRAME_OPEN)
                        begin
                            phase = ucfc_pkg::PH_CMD;
                        end
                        else
                        begin
                            phase = ucfc_pkg::PH_WAIT;
                        end
                    end
                endcase
            end
        endfunction

        function void compare(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_reply(input logic [71:0] d, input logic last);
            reply_beat_t want;
            if (replies.size() == 0)
            begin
                $display("%0t: reply beat with none expected: tdata=%h tlast=%b",
                         $time, d, last);
                errors++;
            end
            else
            begin
                want = replies.pop_front();
                compare("tx_byte", 16'(want.tx_byte), 16'(d[7:0]));
                compare("last_byte", 16'(want.last_byte), 16'(last));
                compare("port_c_level", 16'(want.status.port_c), 16'(d[15:8]));
                compare("heater_enable", 16'(want.status.heater_en), 16'(d[16]));
                compare("light_enable", 16'(want.status.light_en), 16'(d[17]));
                compare("fan_enable", 16'(want.status.fan_en), 16'(d[18]));
                compare("heater_duty", want.status.heater_duty, d[34:19]);
                compare("light_duty", want.status.light_duty, d[50:35]);
                compare("motor_duty", want.status.motor_duty, d[66:51]);
                compare("adc_channel", 16'(want.status.channel), 16'(d[68:67]));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    reply_scoreboard board = new();
    int              items_sent;
    wire             calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    uart_command_frame_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Replies are checked before the input of the same edge is noted; a reply
    // can never come from a beat accepted at that very edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                board.check_reply(m_tdata, m_tlast);
            end
            if (s_tvalid && s_tready)
            begin
                board.note_input(s_tuser, s_tdata);
            end
        end
    end

    initial
    begin : reply_sink
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AT_ITEM)
            begin
                held = 1'b1;
                // Starve the reply side so the controller backs up its input.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout with %0d reply beats outstanding", $time, board.pending());
        $display("tb_uart_command_frame_controller failed");
        $finish;
    end

    task automatic send_beat(input logic kind, input logic [31:0] data);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [7:0] pins);
        logic [15:0] junk;
        junk = 16'($urandom);
        send_beat(1'b0, {pins, junk, b});
        items_sent++;
    endtask

    task automatic send_adc(input logic [15:0] word);
        logic [31:0] junk;
        junk = $urandom;
        send_beat(1'b1, {junk[31:24], word, junk[7:0]});
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input bit long_form,
                              input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] tail, input logic [7:0] pins);
        send_byte(ucfc_pkg::FRAME_OPEN, pins);
        send_byte(cmd, pins);
        if (long_form)
        begin
            send_byte(hi, pins);
            send_byte(lo, pins);
            send_byte(tail, pins);
        end
        else
        begin
            send_byte(ucfc_pkg::FRAME_CLOSE, pins);
        end
    endtask

    initial
    begin : stimulus
        int         pick;
        logic [7:0] cmd;
        logic [7:0] hi;
        logic [7:0] lo;
        bit         long_form;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 32'h0;
        s_tuser    = 1'b0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes outside a frame are dropped.
        send_beat(1'b0, {8'h00, 16'h0000, 8'h00});
        send_beat(1'b0, {8'hFF, 16'hFFFF, ucfc_pkg::FRAME_CLOSE});
        // Before any conversion the ADC reads return zero.
        send_frame(ucfc_pkg::CMD_POT1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(ucfc_pkg::CMD_CHECK, 1'b1, 8'h11, 8'h22, 8'h00, 8'h00);
        send_frame(ucfc_pkg::CMD_SWITCHES, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_frame(ucfc_pkg::CMD_SWITCHES, 1'b1, 8'hAB, 8'hCD, 8'hFF, 8'h00);
        send_adc(16'hFFFF);
        send_frame(ucfc_pkg::CMD_POT2, 1'b0, 8'h00, 8'h00, 8'h00, 8'h5A);
        // A conversion in the middle of a frame leaves the frame intact.
        send_byte(ucfc_pkg::FRAME_OPEN, 8'h5A);
        send_adc(16'h0000);
        send_byte(ucfc_pkg::CMD_TEMP, 8'h5A);
        send_byte(ucfc_pkg::FRAME_CLOSE, 8'h5A);
        send_frame(ucfc_pkg::CMD_LIGHT, 1'b1, 8'h00, 8'h01, ucfc_pkg::FRAME_OPEN, 8'hA5);
        send_frame(ucfc_pkg::CMD_PORTC, 1'b1, 8'hFF, 8'h00, ucfc_pkg::FRAME_CLOSE, 8'hA5);
        send_frame(ucfc_pkg::CMD_HEATER, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'hA5);
        send_frame(ucfc_pkg::CMD_HEATER, 1'b1, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_frame(ucfc_pkg::CMD_LAMP, 1'b1, 8'h12, 8'h34, 8'hFF, 8'hA5);
        // A short frame reuses the data bytes of the last long one.
        send_frame(ucfc_pkg::CMD_LAMP, 1'b0, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_frame(ucfc_pkg::CMD_MOTOR, 1'b1, 8'h80, 8'h01, 8'h00, 8'hA5);
        send_frame(ucfc_pkg::CMD_MOTOR, 1'b1, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_frame(ucfc_pkg::CMD_PORTC, 1'b0, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_frame(8'h77, 1'b0, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_frame(8'hFF, 1'b1, 8'h01, 8'h02, 8'h03, 8'hA5);
        // The close byte in the first data slot ends the frame early.
        send_frame(ucfc_pkg::CMD_PORTC, 1'b1, ucfc_pkg::FRAME_CLOSE, 8'h11, 8'h22, 8'hA5);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_beat(1'b0, $urandom);
            end
            else if (pick < 18)
            begin
                send_adc(16'($urandom));
            end
            else if (pick < 25)
            begin
                // Broken frame: the next item lands in the middle of it.
                send_byte(ucfc_pkg::FRAME_OPEN, 8'($urandom));
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    cmd = 8'($urandom);
                end
                else
                begin
                    cmd = KNOWN_CMDS[$urandom_range(0, 9)];
                end
                long_form = ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 5) == 0)
                begin
                    hi = 8'h00;
                    lo = 8'h00;
                end
                else
                begin
                    hi = 8'($urandom);
                    lo = 8'($urandom);
                end
                send_frame(cmd, long_form, hi, lo, 8'($urandom), 8'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("tb_uart_command_frame_controller passed");
        end
        else
        begin
            $display("tb_uart_command_frame_controller failed");
        end
        $finish;
    end

endmodule

// ----- uart_command_frame_controller.f -----
rtl/core/ucfc_pkg.sv
rtl/core/ucfc_exec.sv
rtl/core/ucfc_tx.sv
rtl/core/uart_command_frame_controller.sv
verif/tb_uart_command_frame_controller.sv
